// ===== rtl/mdhl_pkg.sv =====
// Shared types and constants for the multiply/divide unit with HI/LO registers.
package mdhl_pkg;

   localparam int WORD_W    = 32;
   localparam int ITER_N    = 32;
   localparam int ITER_CW   = $clog2(ITER_N);

   typedef enum logic [2:0] {
      ACT_MULT   = 3'd0,
      ACT_MULTU  = 3'd1,
      ACT_DIV    = 3'd2,
      ACT_DIVU   = 3'd3,
      ACT_MTHI   = 3'd4,
      ACT_MTLO   = 3'd5,
      ACT_MFHI   = 3'd6,
      ACT_MFLO   = 3'd7
   } action_type;

   // Control from the sequencer into the iterative unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } iter_ctrl_type;

   // Status back from the iterative unit.
   typedef struct packed {
      logic busy;
      logic done;
   } iter_stat_type;

endpackage

// ===== rtl/mdhl_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
interface mdhl_req_if;
   logic                         valid;
   logic                         ready;
   logic [2:0]                   action;
   logic [mdhl_pkg::WORD_W-1:0]  operand_a;
   logic [mdhl_pkg::WORD_W-1:0]  operand_b;

   modport source (output valid, output action, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input action, input operand_a, input operand_b,
                   output ready);
endinterface

interface mdhl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mdhl_pkg::WORD_W-1:0]  read_value;
   logic [mdhl_pkg::WORD_W-1:0]  hi_after;
   logic [mdhl_pkg::WORD_W-1:0]  lo_after;

   modport source (output valid, output read_value, output hi_after, output lo_after,
                   input ready);
   modport sink   (input valid, input read_value, input hi_after, input lo_after,
                   output ready);
endinterface

// ===== rtl/mdhl_iter.sv =====
// Radix-2 shift-add multiplier / restoring divider sharing one 34-bit adder.
module mdhl_iter (
   input  logic                          clock,
   input  logic                          reset,
   input  mdhl_pkg::iter_ctrl_type       ctrl,
   input  logic [mdhl_pkg::WORD_W-1:0]   src_a,
   input  logic [mdhl_pkg::WORD_W-1:0]   src_b,
   output mdhl_pkg::iter_stat_type       stat,
   output logic [mdhl_pkg::WORD_W-1:0]   hi,
   output logic [mdhl_pkg::WORD_W-1:0]   lo
);
   localparam int W = mdhl_pkg::WORD_W;

   logic [W-1:0]                  hi_ff, hi_in;
   logic [W-1:0]                  lo_ff, lo_in;
   logic [W-1:0]                  opnd_ff, opnd_in;
   logic                          div_ff, div_in;
   logic                          busy_ff, busy_in;
   logic [mdhl_pkg::ITER_CW-1:0]  cnt_ff, cnt_in;

   logic [W+1:0] add_a, add_b, add_res;
   logic         no_borrow;
   logic         last;

   // Divide: trial subtract of the divisor from the shifted partial remainder.
   // Multiply: add the multiplicand to the upper half.
   always_comb begin
      if (div_ff) begin
         add_a   = {1'b0, hi_ff, lo_ff[W-1]};
         add_b   = ~{2'b00, opnd_ff};
         add_res = add_a + add_b + {{(W+1){1'b0}}, 1'b1};
      end else begin
         add_a   = {2'b00, hi_ff};
         add_b   = {2'b00, opnd_ff};
         add_res = add_a + add_b;
      end
   end

   assign no_borrow = ~add_res[W+1];
   assign last      = (cnt_ff == mdhl_pkg::ITER_CW'(mdhl_pkg::ITER_N - 1));

   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      opnd_in = opnd_ff;
      div_in  = div_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (ctrl.start) begin
         hi_in   = '0;
         div_in  = ctrl.is_div;
         busy_in = 1'b1;
         cnt_in  = '0;
         if (ctrl.is_div) begin
            lo_in   = src_a;
            opnd_in = src_b;
         end else begin
            lo_in   = src_b;
            opnd_in = src_a;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
         if (div_ff) begin
            hi_in = no_borrow ? add_res[W-1:0] : {hi_ff[W-2:0], lo_ff[W-1]};
            lo_in = {lo_ff[W-2:0], no_borrow};
         end else if (lo_ff[0]) begin
            hi_in = add_res[W:1];
            lo_in = {add_res[0], lo_ff[W-1:1]};
         end else begin
            hi_in = {1'b0, hi_ff[W-1:1]};
            lo_in = {hi_ff[0], lo_ff[W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      opnd_ff <= opnd_in;
      div_ff  <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff & last;
   assign hi        = hi_ff;
   assign lo        = lo_ff;

endmodule

// ===== rtl/mult_div_hi_lo_unit.sv =====
// Multiply/divide unit with HI and LO registers: sequencer, HI/LO state and output stage.
//
// Usage: one request transaction on req carries an action (mult, multu, div, divu,
// move to hi, move to lo, read hi, read lo) and two 32-bit operands. Each request
// yields exactly one response transaction on rsp with read_value (hi or lo for
// reads, zero otherwise) and the HI and LO contents after the action.
// Multiplies and divides run on magnitudes through one shared 34-bit adder, one
// bit per cycle, then a sign-fix step. req.ready is high only while the
// sequencer is idle, so a new request is taken only once the last one has
// finished and its response has been handed to the output register.
// Divide by zero and the most-negative-by-minus-one case fall out of the
// restoring algorithm and need no special handling.
// A response waits in the output register while rsp.ready is low; the sequencer
// holds its finished result until that register is free. No new request is
// accepted meanwhile. Reset clears HI, LO, the sequencer state and the iterative
// unit's busy flag and counter; no response is pending after reset.
module mult_div_hi_lo_unit (
   input  logic              clock,
   input  logic              reset,
   mdhl_req_if.sink          req,
   mdhl_rsp_if.source        rsp
);
   localparam int W = mdhl_pkg::WORD_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_FIX  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [W-1:0] hi_word_ff, hi_word_in;
   logic [W-1:0] lo_word_ff, lo_word_in;
   logic [W-1:0] rd_ff, rd_in;
   logic         is_div_ff, is_div_in;
   logic         neg_q_ff, neg_q_in;
   logic         neg_r_ff, neg_r_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_rd_ff, rsp_rd_in;
   logic [W-1:0] rsp_hi_ff, rsp_hi_in;
   logic [W-1:0] rsp_lo_ff, rsp_lo_in;

   mdhl_pkg::action_type    act;
   mdhl_pkg::iter_ctrl_type ctrl;
   mdhl_pkg::iter_stat_type stat;
   logic [W-1:0] mag_a, mag_b, unit_hi, unit_lo;
   logic [2*W-1:0] prod, prod_neg;
   logic         req_fire, sgn, a_neg, b_neg, out_free;

   assign act      = mdhl_pkg::action_type'(req.action);
   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire = req.valid & req.ready;
   assign sgn      = (act == mdhl_pkg::ACT_MULT) || (act == mdhl_pkg::ACT_DIV);
   assign a_neg    = sgn & req.operand_a[W-1];
   assign b_neg    = sgn & req.operand_b[W-1];
   assign mag_a    = a_neg ? (~req.operand_a + 1'b1) : req.operand_a;
   assign mag_b    = b_neg ? (~req.operand_b + 1'b1) : req.operand_b;
   assign out_free = ~rsp_valid_ff | rsp.ready;

   assign prod     = {unit_hi, unit_lo};
   assign prod_neg = ~prod + 1'b1;

   always_comb begin
      ctrl.start  = 1'b0;
      ctrl.is_div = (act == mdhl_pkg::ACT_DIV) || (act == mdhl_pkg::ACT_DIVU);
      state_in    = state_ff;
      hi_word_in  = hi_word_ff;
      lo_word_in  = lo_word_ff;
      rd_in       = rd_ff;
      is_div_in   = is_div_ff;
      neg_q_in    = neg_q_ff;
      neg_r_in    = neg_r_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_in     = '0;
               is_div_in = ctrl.is_div;
               neg_q_in  = a_neg ^ b_neg;
               neg_r_in  = a_neg;
               unique case (act)
                  mdhl_pkg::ACT_MULT, mdhl_pkg::ACT_MULTU,
                  mdhl_pkg::ACT_DIV, mdhl_pkg::ACT_DIVU: begin
                     ctrl.start = 1'b1;
                     state_in   = ST_RUN;
                  end
                  mdhl_pkg::ACT_MTHI: begin
                     hi_word_in = req.operand_a;
                     state_in   = ST_DONE;
                  end
                  mdhl_pkg::ACT_MTLO: begin
                     lo_word_in = req.operand_a;
                     state_in   = ST_DONE;
                  end
                  mdhl_pkg::ACT_MFHI: begin
                     rd_in    = hi_word_ff;
                     state_in = ST_DONE;
                  end
                  default: begin
                     rd_in    = lo_word_ff;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (stat.done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (is_div_ff) begin
               lo_word_in = neg_q_ff ? (~unit_lo + 1'b1) : unit_lo;
               hi_word_in = neg_r_ff ? (~unit_hi + 1'b1) : unit_hi;
            end else begin
               {hi_word_in, lo_word_in} = neg_q_ff ? prod_neg : prod;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_rd_in    = rsp_rd_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_lo_in    = rsp_lo_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_rd_in    = rd_ff;
         rsp_hi_in    = hi_word_ff;
         rsp_lo_in    = lo_word_ff;
      end
   end

   mdhl_iter u_iter (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .src_a (mag_a),
      .src_b (mag_b),
      .stat  (stat),
      .hi    (unit_hi),
      .lo    (unit_lo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hi_word_ff   <= '0;
         lo_word_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hi_word_ff   <= hi_word_in;
         lo_word_ff   <= lo_word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ff     <= rd_in;
      is_div_ff <= is_div_in;
      neg_q_ff  <= neg_q_in;
      neg_r_ff  <= neg_r_in;
      rsp_rd_ff <= rsp_rd_in;
      rsp_hi_ff <= rsp_hi_in;
      rsp_lo_ff <= rsp_lo_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_value = rsp_rd_ff;
   assign rsp.hi_after   = rsp_hi_ff;
   assign rsp.lo_after   = rsp_lo_ff;

   // Sequencer and iterative unit agree on when the unit is working.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> stat.busy)
      else $error("sequencer in run state while unit idle");

   a_done_fix: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> (state_ff == ST_FIX))
      else $error("unit finished but sequencer missed the sign fix");

   // HI/LO change only while handling an accepted transaction.
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && !req_fire) |=> ($stable(hi_word_ff) && $stable(lo_word_ff)))
      else $error("hi/lo changed with no transaction");

   a_read_hi: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (act == mdhl_pkg::ACT_MFHI)) |=> (rd_ff == $past(hi_word_ff)))
      else $error("read hi captured wrong value");

endmodule

// ===== test/tb_mult_div_hi_lo_unit.sv =====
`timescale 1ns / 1ps
// Testbench for the HI/LO multiply/divide unit: directed and random transactions checked by a scoreboard.
module tb_mult_div_hi_lo_unit;

   localparam logic [31:0] SIGN_BIT      = 32'h8000_0000;
   localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;
   localparam logic [31:0] MAX_POS       = 32'h7fff_ffff;
   localparam int          RANDOM_ITEMS  = 1400;
   localparam int          PHASES        = 4;
   localparam int          SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [31:0] read_value;
      logic [31:0] hi_after;
      logic [31:0] lo_after;
   } hilo_result_type;

   // Tracks HI/LO as the unit should hold them and queues the response each request owes.
   class hilo_scoreboard;
      logic [31:0]     hi_reg = '0;
      logic [31:0]     lo_reg = '0;
      hilo_result_type expected_q[$];
      int              errors = 0;

      function void note_request(mdhl_pkg::action_type act, logic [31:0] a, logic [31:0] b);
         logic [63:0] product;
         logic [31:0] mag_n, mag_d, quot, rem, rd;
         rd = '0;
         case (act)
            mdhl_pkg::ACT_MULT: begin
               product = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
               {hi_reg, lo_reg} = product;
            end
            mdhl_pkg::ACT_MULTU: begin
               product = {32'b0, a} * {32'b0, b};
               {hi_reg, lo_reg} = product;
            end
            mdhl_pkg::ACT_DIV: begin
               if (b == '0) begin
                  hi_reg = a;
                  lo_reg = a[31] ? 32'd1 : ALL_ONES;
               end else if (a == SIGN_BIT && b == ALL_ONES) begin
                  hi_reg = '0;
                  lo_reg = SIGN_BIT;
               end else begin
                  // truncate toward zero; remainder follows the numerator's sign
                  mag_n  = a[31] ? -a : a;
                  mag_d  = b[31] ? -b : b;
                  quot   = mag_n / mag_d;
                  rem    = mag_n % mag_d;
                  lo_reg = (a[31] != b[31]) ? -quot : quot;
                  hi_reg = a[31] ? -rem : rem;
               end
            end
            mdhl_pkg::ACT_DIVU: begin
               if (b == '0) begin
                  hi_reg = a;
                  lo_reg = ALL_ONES;
               end else begin
                  hi_reg = a % b;
                  lo_reg = a / b;
               end
            end
            mdhl_pkg::ACT_MTHI: hi_reg = a;
            mdhl_pkg::ACT_MTLO: lo_reg = a;
            mdhl_pkg::ACT_MFHI: rd = hi_reg;
            mdhl_pkg::ACT_MFLO: rd = lo_reg;
         endcase
         expected_q.push_back('{read_value: rd, hi_after: hi_reg, lo_after: lo_reg});
      endfunction

      function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_response(hilo_result_type got);
         hilo_result_type exp_r;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: response with nothing outstanding, expected none, actual %h/%h/%h",
                     $time, got.read_value, got.hi_after, got.lo_after);
            return;
         end
         exp_r = expected_q.pop_front();
         check_field("read_value", exp_r.read_value, got.read_value);
         check_field("hi_after", exp_r.hi_after, got.hi_after);
         check_field("lo_after", exp_r.lo_after, got.lo_after);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   no_idle;

   mdhl_req_if req_if ();
   mdhl_rsp_if rsp_if ();

   hilo_scoreboard sb;

   mult_div_hi_lo_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one request and hold it until the unit takes it.
   task send_item(input mdhl_pkg::action_type act, input logic [31:0] a,
                  input logic [31:0] b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.action    <= act;
      req_if.operand_a <= a;
      req_if.operand_b <= b;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(act, a, b);
   endtask

   task drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function logic [31:0] rand_word();
      logic [31:0] w;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: w = $urandom;
         4:          w = $urandom_range(0, 15);
         5:          w = -$urandom_range(1, 16);
         6:          w = $urandom >> $urandom_range(0, 31);
         7:          w = SIGN_BIT | $urandom_range(0, 3);
         8:          w = MAX_POS - $urandom_range(0, 3);
         default:    w = ($urandom_range(0, 1) != 0) ? ALL_ONES : 32'd1;
      endcase
      return w;
   endfunction

   task send_random_item();
      mdhl_pkg::action_type act;
      logic [31:0]          a, b;
      act = mdhl_pkg::action_type'($urandom_range(0, 7));
      a   = rand_word();
      b   = ($urandom_range(0, 19) == 0) ? '0 : rand_word();
      // most-negative over minus one now and then
      if (act == mdhl_pkg::ACT_DIV && $urandom_range(0, 39) == 0) begin
         a = SIGN_BIT;
         b = ALL_ONES;
      end
      send_item(act, a, b);
   endtask

   // Response side: random stalls, check every accepted transaction.
   initial begin
      int              stall;
      hilo_result_type got;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got = '{read_value: rsp_if.read_value, hi_after: rsp_if.hi_after,
                 lo_after: rsp_if.lo_after};
         sb.check_response(got);
      end
   end

   initial begin
      sb               = new();
      no_idle          = 1'b0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.action    <= mdhl_pkg::ACT_MULT;
      req_if.operand_a <= '0;
      req_if.operand_b <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_item(mdhl_pkg::ACT_MFHI,  '0, '0);
      send_item(mdhl_pkg::ACT_MFLO,  '0, '0);
      send_item(mdhl_pkg::ACT_MTHI,  ALL_ONES, '0);
      send_item(mdhl_pkg::ACT_MTLO,  '0, ALL_ONES);
      send_item(mdhl_pkg::ACT_MFHI,  '0, '0);
      send_item(mdhl_pkg::ACT_MFLO,  '0, '0);
      send_item(mdhl_pkg::ACT_MULT,  SIGN_BIT, SIGN_BIT);
      send_item(mdhl_pkg::ACT_MULT,  ALL_ONES, 32'd1);
      send_item(mdhl_pkg::ACT_MULT,  MAX_POS, SIGN_BIT);
      send_item(mdhl_pkg::ACT_MULTU, ALL_ONES, ALL_ONES);
      send_item(mdhl_pkg::ACT_MULTU, '0, ALL_ONES);
      send_item(mdhl_pkg::ACT_DIVU,  32'h1234_5678, '0);
      send_item(mdhl_pkg::ACT_DIV,   32'd7, '0);
      send_item(mdhl_pkg::ACT_DIV,   -32'd7, '0);
      send_item(mdhl_pkg::ACT_DIV,   '0, '0);
      send_item(mdhl_pkg::ACT_DIV,   SIGN_BIT, ALL_ONES);
      send_item(mdhl_pkg::ACT_DIV,   -32'd7, 32'd2);
      send_item(mdhl_pkg::ACT_DIV,   32'd7, -32'd2);
      send_item(mdhl_pkg::ACT_DIV,   SIGN_BIT, 32'd1);
      send_item(mdhl_pkg::ACT_DIVU,  ALL_ONES, 32'd1);
      send_item(mdhl_pkg::ACT_DIVU,  32'd5, 32'd7);
      send_item(mdhl_pkg::ACT_MFHI,  ALL_ONES, ALL_ONES);
      send_item(mdhl_pkg::ACT_MFLO,  ALL_ONES, ALL_ONES);
      drain_results();

      for (int phase = 0; phase < PHASES; phase++) begin
         no_idle = (phase == 2);
         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
            send_random_item();
            if ($urandom_range(0, 49) == 0)
               drain_results();
         end
         drain_results();
      end
      no_idle = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mdhl_pkg.sv
rtl/mdhl_if.sv
rtl/mdhl_iter.sv
rtl/mult_div_hi_lo_unit.sv
test/tb_mult_div_hi_lo_unit.sv
